### rtl/ggca_pkg.sv
// Shared types, constants and the control store for the greedy grid cleaning agent.
// Used by ggca_seq and greedy_grid_cleaning_agent_unit; depends on nothing.

package ggca_pkg;

  // Field widths
  localparam int POS_W    = 4;
  localparam int GRID_W   = 5;
  localparam int BATT_W   = 16;
  localparam int CNT_W    = 32;
  localparam int DIST_W   = POS_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Largest grid side that the position fields can address
  localparam int POS_LIMIT = 1 << POS_W;

  // Parameter defaults
  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;

  // Configuration reset values
  localparam logic [GRID_W-1:0] RST_GRID_ROWS   = GRID_W'(16);
  localparam logic [GRID_W-1:0] RST_GRID_COLS   = GRID_W'(16);
  localparam logic [BATT_W-1:0] RST_FULL_CHARGE = BATT_W'(100);
  localparam logic [BATT_W-1:0] RST_LOW_BATTERY = BATT_W'(20);

  // Input word kinds
  localparam logic KIND_MARK = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS   = 2'd0,
    CFG_GRID_COLS   = 2'd1,
    CFG_FULL_CHARGE = 2'd2,
    CFG_LOW_BATTERY = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] cell_row;
    logic [POS_W-1:0] cell_col;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_row;
    logic [POS_W-1:0]  pos_col;
    logic              cleaned;
    logic              all_clean;
    logic              recharged;
    logic              stranded;
    logic [BATT_W-1:0] battery_left;
    logic [CNT_W-1:0]  action_total;
  } out_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_SCAN,
    OP_HOME_ALL,
    OP_GO_TARGET,
    OP_READ_POS,
    OP_CLEAN,
    OP_HOME,
    OP_EMIT
  } op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLEAR_BUSY,
    C_NO_ACCEPT,
    C_MARK,
    C_SCAN_BUSY,
    C_FOUND,
    C_ABOVE_LOW,
    C_OUT_BLOCKED
  } cond_e;

  localparam int PC_W = 4;

  // Program steps
  localparam logic [PC_W-1:0] ST_CLEAR   = 4'd0;
  localparam logic [PC_W-1:0] ST_WAIT    = 4'd1;
  localparam logic [PC_W-1:0] ST_KIND    = 4'd2;
  localparam logic [PC_W-1:0] ST_SCAN    = 4'd3;
  localparam logic [PC_W-1:0] ST_PICK    = 4'd4;
  localparam logic [PC_W-1:0] ST_NO_DIRT = 4'd5;
  localparam logic [PC_W-1:0] ST_GO      = 4'd6;
  localparam logic [PC_W-1:0] ST_READ    = 4'd7;
  localparam logic [PC_W-1:0] ST_CLEAN   = 4'd8;
  localparam logic [PC_W-1:0] ST_LOW     = 4'd9;
  localparam logic [PC_W-1:0] ST_HOME    = 4'd10;
  localparam logic [PC_W-1:0] ST_HOLD    = 4'd11;
  localparam logic [PC_W-1:0] ST_EMIT    = 4'd12;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  // Status flags that the datapath offers to the sequencer
  typedef struct packed {
    logic clear_busy;
    logic accept;
    logic is_mark;
    logic scan_busy;
    logic found;
    logic above_low;
    logic out_blocked;
  } cond_t;

  // Control store: next step is target when the condition holds, else the following step
  function automatic cw_t ucode_rom(input logic [PC_W-1:0] pc);
    cw_t cw;
    unique case (pc)
      ST_CLEAR:   cw = '{op: OP_CLEAR,     cond: C_CLEAR_BUSY,  target: ST_CLEAR};
      ST_WAIT:    cw = '{op: OP_ACCEPT,    cond: C_NO_ACCEPT,   target: ST_WAIT};
      ST_KIND:    cw = '{op: OP_NOP,       cond: C_MARK,        target: ST_HOLD};
      ST_SCAN:    cw = '{op: OP_SCAN,      cond: C_SCAN_BUSY,   target: ST_SCAN};
      ST_PICK:    cw = '{op: OP_NOP,       cond: C_FOUND,       target: ST_GO};
      ST_NO_DIRT: cw = '{op: OP_HOME_ALL,  cond: C_ALWAYS,      target: ST_HOLD};
      ST_GO:      cw = '{op: OP_GO_TARGET, cond: C_NEVER,       target: ST_WAIT};
      ST_READ:    cw = '{op: OP_READ_POS,  cond: C_NEVER,       target: ST_WAIT};
      ST_CLEAN:   cw = '{op: OP_CLEAN,     cond: C_NEVER,       target: ST_WAIT};
      ST_LOW:     cw = '{op: OP_NOP,       cond: C_ABOVE_LOW,   target: ST_HOLD};
      ST_HOME:    cw = '{op: OP_HOME,      cond: C_NEVER,       target: ST_WAIT};
      ST_HOLD:    cw = '{op: OP_NOP,       cond: C_OUT_BLOCKED, target: ST_HOLD};
      ST_EMIT:    cw = '{op: OP_EMIT,      cond: C_ALWAYS,      target: ST_WAIT};
      default:    cw = '{op: OP_NOP,       cond: C_ALWAYS,      target: ST_WAIT};
    endcase
    return cw;
  endfunction

endpackage

### rtl/greedy_grid_cleaning_agent_unit.sv
// Top level of the greedy grid cleaning agent: dirt map memory, datapath and configuration.
// Depends on ggca_pkg and on ggca_seq, which steps through the control store.

// The block keeps a map of dirty cells, the cleaner position, its battery and a saturating
// action count. A mark word (kind 0) sets one in-range cell dirty and answers with the
// current state through the ST_KIND, ST_HOLD and ST_EMIT steps. A step word (kind 1) runs
// one round of the greedy agent: the dirt map is read one cell per cycle in row-major order
// over the active rows times columns through its single read port; when no dirt is found
// the cleaner heads home, else it goes for the nearest dirty cell, cleans it and heads back
// to the charger if its battery is at or below the low mark. An empty active grid reads no
// cell. A stalled result word holds back the next result. One word is worked at a time;
// the next input is taken as soon as the result sits in the output register, even while
// the downstream side still stalls it. After reset the dirt map is cleared one entry per
// cycle, all 256 entries at the default size, while the input stays stalled; configuration
// writes are taken at any time, but write them only between words, since a write during
// a round changes that round.
module greedy_grid_cleaning_agent_unit #(
  parameter int MAX_ROWS = ggca_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ggca_pkg::DEF_MAX_COLS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ggca_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ggca_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ggca_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ggca_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ggca_pkg::*;

  // Only cells that the position fields can name are ever marked
  localparam int EFF_R = (MAX_ROWS < POS_LIMIT) ? MAX_ROWS : POS_LIMIT;
  localparam int EFF_C = (MAX_COLS < POS_LIMIT) ? MAX_COLS : POS_LIMIT;
  localparam int RB    = (EFF_R > 1) ? $clog2(EFF_R) : 1;
  localparam int CB    = (EFF_C > 1) ? $clog2(EFF_C) : 1;
  localparam int AW    = RB + CB;
  localparam int DEPTH = 1 << AW;
  localparam logic [GRID_W-1:0] EFF_R_L = GRID_W'(EFF_R);
  localparam logic [GRID_W-1:0] EFF_C_L = GRID_W'(EFF_C);

  function automatic logic [AW-1:0] cell_addr(input logic [POS_W-1:0] r,
                                              input logic [POS_W-1:0] c);
    return {r[RB-1:0], c[CB-1:0]};
  endfunction

  function automatic logic [DIST_W-1:0] manhattan(input logic [POS_W-1:0] ar,
                                                  input logic [POS_W-1:0] ac,
                                                  input logic [POS_W-1:0] br,
                                                  input logic [POS_W-1:0] bc);
    logic [POS_W-1:0] dr;
    logic [POS_W-1:0] dc;
    dr = (ar > br) ? ar - br : br - ar;
    dc = (ac > bc) ? ac - bc : bc - ac;
    return {1'b0, dr} + {1'b0, dc};
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [DIST_W-1:0] n);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {{(CNT_W+1-DIST_W){1'b0}}, n};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

  // Sequencer
  cw_t   cw;
  cond_t cond;

  ggca_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .cw_o   (cw)
  );

  // Configuration registers
  logic [GRID_W-1:0] grid_rows_q, grid_cols_q;
  logic [BATT_W-1:0] full_q, low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= RST_GRID_ROWS;
      grid_cols_q <= RST_GRID_COLS;
      full_q      <= RST_FULL_CHARGE;
      low_q       <= RST_LOW_BATTERY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_ROWS:   grid_rows_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_COLS:   grid_cols_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_FULL_CHARGE: full_q      <= cfg_wdata_i[BATT_W-1:0];
        CFG_LOW_BATTERY: low_q       <= cfg_wdata_i[BATT_W-1:0];
        default: ;
      endcase
    end
  end

  // Active grid: the configured size, capped at the largest size the dirt map can hold
  logic [GRID_W-1:0] act_rows, act_cols;
  assign act_rows = (grid_rows_q < EFF_R_L) ? grid_rows_q : EFF_R_L;
  assign act_cols = (grid_cols_q < EFF_C_L) ? grid_cols_q : EFF_C_L;

  // Dirt map memory: one write and one registered read per cycle
  logic          dirt_mem [DEPTH];
  logic          mem_we, mem_wdata, mem_re, rdata_q;
  logic [AW-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dirt_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= dirt_mem[mem_raddr];
    end
  end

  // Agent state
  logic [AW-1:0]     clr_q, clr_d;
  logic [POS_W-1:0]  pos_r_q, pos_r_d, pos_c_q, pos_c_d;
  logic [BATT_W-1:0] batt_q, batt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              kind_q, kind_d;
  logic              cleaned_q, cleaned_d, all_clean_q, all_clean_d;
  logic              recharged_q, recharged_d, stranded_q, stranded_d;

  // Scan state
  logic [POS_W-1:0]  sr_q, sr_d, sc_q, sc_d;
  logic              issue_q, issue_d;
  logic              pend_v_q, pend_v_d;
  logic [POS_W-1:0]  pend_r_q, pend_r_d, pend_c_q, pend_c_d;
  logic              found_q, found_d;
  logic [DIST_W-1:0] best_q, best_d;
  logic [POS_W-1:0]  tr_q, tr_d, tc_q, tc_d;

  // Output register
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic accept;
  assign in_stall_o = (cw.op != OP_ACCEPT);
  assign accept     = in_valid_i && !in_stall_o;

  assign cond.clear_busy  = (clr_q != {AW{1'b1}});
  assign cond.accept      = accept;
  assign cond.is_mark     = (kind_q == KIND_MARK);
  assign cond.scan_busy   = issue_q || pend_v_q;
  assign cond.found       = found_q;
  assign cond.above_low   = (batt_q > low_q);
  assign cond.out_blocked = out_valid_q && out_stall_i;

  // Travel: toward the target found by the scan or home to the charger
  logic [POS_W-1:0]  trav_r, trav_c;
  logic [DIST_W-1:0] trav_dist;
  logic              trav_ok;
  logic [BATT_W-1:0] trav_batt;
  logic [CNT_W-1:0]  trav_cnt;

  assign trav_r    = (cw.op == OP_GO_TARGET) ? tr_q : '0;
  assign trav_c    = (cw.op == OP_GO_TARGET) ? tc_q : '0;
  assign trav_dist = manhattan(pos_r_q, pos_c_q, trav_r, trav_c);
  assign trav_ok   = (trav_dist == '0) ||
                     ({{(BATT_W-DIST_W){1'b0}}, trav_dist} < batt_q);
  assign trav_batt = batt_q - {{(BATT_W-DIST_W){1'b0}}, trav_dist};
  assign trav_cnt  = sat_add(cnt_q, trav_dist);

  // Distance of the cell whose dirt bit is arriving from the memory
  logic [DIST_W-1:0] scan_dist;
  assign scan_dist = manhattan(pos_r_q, pos_c_q, pend_r_q, pend_c_q);

  logic mark_in_range;
  assign mark_in_range = ({1'b0, in_data_i.cell_row} < EFF_R_L) &&
                         ({1'b0, in_data_i.cell_col} < EFF_C_L);

  always_comb begin
    clr_d       = clr_q;
    pos_r_d     = pos_r_q;
    pos_c_d     = pos_c_q;
    batt_d      = batt_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    cleaned_d   = cleaned_q;
    all_clean_d = all_clean_q;
    recharged_d = recharged_q;
    stranded_d  = stranded_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    issue_d     = issue_q;
    pend_v_d    = pend_v_q;
    pend_r_d    = pend_r_q;
    pend_c_d    = pend_c_q;
    found_d     = found_q;
    best_d      = best_q;
    tr_d        = tr_q;
    tc_d        = tc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (cw.op)
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      OP_ACCEPT: begin
        if (accept) begin
          kind_d      = in_data_i.kind;
          cleaned_d   = 1'b0;
          all_clean_d = 1'b0;
          recharged_d = 1'b0;
          stranded_d  = 1'b0;
          sr_d        = '0;
          sc_d        = '0;
          issue_d     = (act_rows != '0) && (act_cols != '0);
          pend_v_d    = 1'b0;
          found_d     = 1'b0;
          if (in_data_i.kind == KIND_MARK && mark_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(in_data_i.cell_row, in_data_i.cell_col);
            mem_wdata = 1'b1;
          end
        end
      end
      OP_SCAN: begin
        // Issue the next cell read and judge the one read last cycle
        pend_v_d = issue_q;
        pend_r_d = sr_q;
        pend_c_d = sc_q;
        if (issue_q) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(sr_q, sc_q);
          if (({1'b0, sc_q} + 1'b1) == act_cols) begin
            sc_d = '0;
            if (({1'b0, sr_q} + 1'b1) == act_rows) begin
              issue_d = 1'b0;
            end else begin
              sr_d = sr_q + 1'b1;
            end
          end else begin
            sc_d = sc_q + 1'b1;
          end
        end
        if (pend_v_q && rdata_q && (!found_q || scan_dist < best_q)) begin
          found_d = 1'b1;
          best_d  = scan_dist;
          tr_d    = pend_r_q;
          tc_d    = pend_c_q;
        end
      end
      OP_HOME_ALL, OP_HOME: begin
        if (trav_ok) begin
          pos_r_d     = '0;
          pos_c_d     = '0;
          cnt_d       = trav_cnt;
          batt_d      = full_q;
          recharged_d = 1'b1;
          all_clean_d = (cw.op == OP_HOME_ALL);
        end else begin
          stranded_d = 1'b1;
        end
      end
      OP_GO_TARGET: begin
        if (trav_ok) begin
          pos_r_d = tr_q;
          pos_c_d = tc_q;
          batt_d  = trav_batt;
          cnt_d   = trav_cnt;
        end else begin
          stranded_d = 1'b1;
        end
      end
      OP_READ_POS: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr(pos_r_q, pos_c_q);
      end
      OP_CLEAN: begin
        if (rdata_q) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(pos_r_q, pos_c_q);
          batt_d    = (batt_q == '0) ? '0 : batt_q - 1'b1;
          cnt_d     = sat_add(cnt_q, DIST_W'(1));
          cleaned_d = 1'b1;
        end
      end
      OP_EMIT: begin
        out_valid_d        = 1'b1;
        out_d.pos_row      = pos_r_q;
        out_d.pos_col      = pos_c_q;
        out_d.cleaned      = cleaned_q;
        out_d.all_clean    = all_clean_q;
        out_d.recharged    = recharged_q;
        out_d.stranded     = stranded_q;
        out_d.battery_left = batt_q;
        out_d.action_total = cnt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      pos_r_q     <= '0;
      pos_c_q     <= '0;
      batt_q      <= RST_FULL_CHARGE;
      cnt_q       <= '0;
      kind_q      <= KIND_MARK;
      cleaned_q   <= 1'b0;
      all_clean_q <= 1'b0;
      recharged_q <= 1'b0;
      stranded_q  <= 1'b0;
      issue_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      pos_r_q     <= pos_r_d;
      pos_c_q     <= pos_c_d;
      batt_q      <= batt_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      cleaned_q   <= cleaned_d;
      all_clean_q <= all_clean_d;
      recharged_q <= recharged_d;
      stranded_q  <= stranded_d;
      issue_q     <= issue_d;
      pend_v_q    <= pend_v_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Scan bookkeeping and the result word carry no reset
  always_ff @(posedge clk_i) begin
    sr_q     <= sr_d;
    sc_q     <= sc_d;
    pend_r_q <= pend_r_d;
    pend_c_q <= pend_c_d;
    best_q   <= best_d;
    tr_q     <= tr_d;
    tc_q     <= tc_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/ggca_seq.sv
// Step counter and control store lookup for the cleaning agent.
// Depends on ggca_pkg for the control word, condition flags and program.

module ggca_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ggca_pkg::cond_t cond_i,
  output ggca_pkg::cw_t   cw_o
);
  import ggca_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  cw_t             cw;
  logic            take;

  assign cw   = ucode_rom(pc_q);
  assign cw_o = cw;

  always_comb begin
    unique case (cw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_CLEAR_BUSY:  take = cond_i.clear_busy;
      C_NO_ACCEPT:   take = !cond_i.accept;
      C_MARK:        take = cond_i.is_mark;
      C_SCAN_BUSY:   take = cond_i.scan_busy;
      C_FOUND:       take = cond_i.found;
      C_ABOVE_LOW:   take = cond_i.above_low;
      C_OUT_BLOCKED: take = cond_i.out_blocked;
      default:       take = 1'b0;
    endcase
    pc_d = take ? cw.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
